// ===== src/sbfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, report codes and control structs of the SBUS frame receiver.
// No dependencies; imported by the controller, the datapath and the top level.
package sbfr_pkg;

	// Frame layout
	localparam int FRAME_BYTES     = 25;
	localparam int ANALOG_CHANNELS = 16;
	localparam int CHAN_BITS       = 11;
	localparam int POS_BITS        = 5;
	localparam int CHAN_IDX_BITS   = 5;
	localparam int ACC_BITS        = CHAN_BITS + 7;
	localparam int NBITS_BITS      = 5;

	localparam logic [POS_BITS-1:0] FIRST_DATA_POS = POS_BITS'(1);
	localparam logic [POS_BITS-1:0] LAST_DATA_POS  = POS_BITS'(22);
	localparam logic [POS_BITS-1:0] FLAGS_POS      = POS_BITS'(23);
	localparam logic [POS_BITS-1:0] FRAME_LEN      = POS_BITS'(FRAME_BYTES);

	localparam logic [7:0] START_MARK = 8'h0F;
	localparam logic [7:0] END_MARK   = 8'h00;

	// Flag byte bits
	localparam int FLAG_DIG0     = 0;
	localparam int FLAG_DIG1     = 1;
	localparam int FLAG_FAILSAFE = 3;

	// Channel indexes
	localparam logic [CHAN_IDX_BITS-1:0] LAST_ANALOG_CH = CHAN_IDX_BITS'(ANALOG_CHANNELS - 1);
	localparam logic [CHAN_IDX_BITS-1:0] DIG0_CH        = CHAN_IDX_BITS'(ANALOG_CHANNELS);
	localparam logic [CHAN_IDX_BITS-1:0] DIG1_CH        = CHAN_IDX_BITS'(ANALOG_CHANNELS + 1);

	// Saturation limits
	localparam logic [10:0] ELAPSED_MAX = 11'd2047;
	localparam logic [15:0] ERRORS_MAX  = 16'hFFFF;

	// Input kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Report codes
	localparam logic [1:0] REPORT_CHANNEL = 2'd0;
	localparam logic [1:0] REPORT_BAD     = 2'd1;
	localparam logic [1:0] REPORT_STATUS  = 2'd2;

	// Configuration registers
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 11;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DIG_LOW    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DIG_HIGH   = 2'd2;
	localparam logic [9:0]  TIMEOUT_RESET  = 10'd100;
	localparam logic [10:0] DIG_LOW_RESET  = 11'd172;
	localparam logic [10:0] DIG_HIGH_RESET = 11'd1811;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic fetch;
		logic merge;
		logic emit_analog;
		logic emit_digital;
	} sbfr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic frame_good;
		logic out_free;
		logic have_chan;
		logic last_analog;
		logic last_digital;
	} sbfr_status_t;

endpackage

// ===== src/sbfr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the SBUS frame receiver: input handshake and frame decode sequencing.
// Depends on sbfr_pkg for the command and status structs.
module sbfr_ctrl
	import sbfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  sbfr_status_t status,
	output sbfr_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_FETCH   = 3'd1;
	localparam logic [2:0] ST_MERGE   = 3'd2;
	localparam logic [2:0] ST_EMIT    = 3'd3;
	localparam logic [2:0] ST_DIGITAL = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Inputs are taken only while idle and with room in the output register
	assign in_ready = (state_q == ST_IDLE) && status.out_free;

	// Next state and commands
	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		cmd.accept       = in_valid && in_ready;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.frame_good) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_MERGE;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.have_chan) begin
					state_d = ST_FETCH;
				end else if (status.out_free) begin
					cmd.emit_analog = 1'b1;
					if (status.last_analog) begin
						state_d = ST_DIGITAL;
					end
				end
			end
			ST_DIGITAL: begin
				if (status.out_free) begin
					cmd.emit_digital = 1'b1;
					if (status.last_digital) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/sbfr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the SBUS frame receiver: frame store, capture and link state,
// channel bit unpacker, configuration registers and output register. Uses sbfr_pkg.
module sbfr_datapath
	import sbfr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      kind,
	input  logic [7:0]                rx_byte,
	input  sbfr_cmd_t                 cmd,
	output sbfr_status_t              status,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                report,
	output logic [4:0]                channel,
	output logic [10:0]               value,
	output logic                      failsafe,
	output logic                      lost,
	output logic [15:0]               error_count,
	output logic                      last
);

	// Configuration
	logic [9:0]  timeout_q;
	logic [10:0] dig_low_q;
	logic [10:0] dig_high_q;

	// Capture and link state
	logic [POS_BITS-1:0] pos_q;
	logic                cap_q;
	logic [7:0]          prev_q;
	logic [7:0]          first_q;
	logic [7:0]          flags_q;
	logic                failsafe_q;
	logic [10:0]         elapsed_q;
	logic [15:0]         bad_q;

	// Unpacker
	logic [7:0]                mem [FRAME_BYTES];
	logic [7:0]                rdata_q;
	logic [POS_BITS-1:0]       rd_q;
	logic [ACC_BITS-1:0]       acc_q;
	logic [NBITS_BITS-1:0]     nbits_q;
	logic [CHAN_IDX_BITS-1:0]  ch_q;

	// Input decode
	logic                is_byte;
	logic                is_tick;
	logic                start;
	logic [POS_BITS-1:0] pos;
	logic                cap;
	logic [POS_BITS-1:0] pos_n;
	logic                mem_we;
	logic                done;
	logic                good;
	logic                bad;
	logic [10:0]         elapsed_inc;
	logic [15:0]         bad_inc;
	logic                dig_bit;
	logic                load;

	assign is_byte     = cmd.accept && (kind == KIND_BYTE);
	assign is_tick     = cmd.accept && (kind == KIND_TICK);
	assign start       = (rx_byte == START_MARK) && (prev_q == END_MARK);
	assign pos         = start ? '0 : pos_q;
	assign cap         = start || cap_q;
	assign pos_n       = pos + POS_BITS'(1);
	assign mem_we      = is_byte && cap && (pos < FRAME_LEN);
	assign done        = cap && (pos_n >= FRAME_LEN) && (kind == KIND_BYTE);
	assign good        = done && (rx_byte == END_MARK) && (first_q == START_MARK);
	assign bad         = is_byte && done && !good;
	assign elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 11'd1 : elapsed_q;
	assign bad_inc     = (bad_q < ERRORS_MAX) ? bad_q + 16'd1 : bad_q;
	assign dig_bit     = (ch_q == DIG0_CH) ? flags_q[FLAG_DIG0] : flags_q[FLAG_DIG1];
	assign load        = is_tick || bad || cmd.emit_analog || cmd.emit_digital;

	// Status to controller
	assign status.frame_good   = good;
	assign status.out_free     = !out_valid || out_ready;
	assign status.have_chan    = nbits_q >= NBITS_BITS'(CHAN_BITS);
	assign status.last_analog  = ch_q == LAST_ANALOG_CH;
	assign status.last_digital = ch_q == DIG1_CH;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			dig_low_q  <= DIG_LOW_RESET;
			dig_high_q <= DIG_HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT:  timeout_q  <= cfg_data[9:0];
				CFG_DIG_LOW:  dig_low_q  <= cfg_data;
				CFG_DIG_HIGH: dig_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Frame store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos] <= rx_byte;
		end
		if (cmd.fetch) begin
			rdata_q <= mem[rd_q];
		end
	end

	// First and flag bytes kept aside for the frame checks
	always_ff @(posedge clk) begin
		if (mem_we && (pos == '0)) begin
			first_q <= rx_byte;
		end
		if (mem_we && (pos == FLAGS_POS)) begin
			flags_q <= rx_byte;
		end
	end

	// Capture and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			cap_q      <= 1'b0;
			prev_q     <= '0;
			failsafe_q <= 1'b0;
			elapsed_q  <= '0;
			bad_q      <= '0;
		end else if (is_tick) begin
			elapsed_q <= elapsed_inc;
		end else if (is_byte) begin
			prev_q <= rx_byte;
			if (start) begin
				elapsed_q <= '0;
			end
			if (cap) begin
				pos_q <= pos_n;
				cap_q <= !done;
			end else begin
				pos_q <= pos;
				cap_q <= cap;
			end
			if (good) begin
				elapsed_q  <= '0;
				failsafe_q <= flags_q[FLAG_FAILSAFE];
			end
			if (bad) begin
				bad_q <= bad_inc;
			end
		end
	end

	// Bit unpacker: bytes enter at the top of the accumulator, channels leave at the bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= FIRST_DATA_POS;
			acc_q   <= '0;
			nbits_q <= '0;
			ch_q    <= '0;
		end else if (is_byte && good) begin
			rd_q    <= FIRST_DATA_POS;
			acc_q   <= '0;
			nbits_q <= '0;
			ch_q    <= '0;
		end else begin
			if (cmd.fetch) begin
				rd_q <= rd_q + POS_BITS'(1);
			end
			if (cmd.merge) begin
				acc_q   <= acc_q | (ACC_BITS'(rdata_q) << nbits_q);
				nbits_q <= nbits_q + NBITS_BITS'(8);
			end
			if (cmd.emit_analog) begin
				acc_q   <= acc_q >> CHAN_BITS;
				nbits_q <= nbits_q - NBITS_BITS'(CHAN_BITS);
			end
			if (cmd.emit_analog || cmd.emit_digital) begin
				ch_q <= ch_q + CHAN_IDX_BITS'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			report      <= REPORT_STATUS;
			channel     <= '0;
			value       <= '0;
			failsafe    <= failsafe_q;
			lost        <= (elapsed_inc > {1'b0, timeout_q}) || failsafe_q;
			error_count <= bad_q;
			last        <= 1'b1;
		end else if (bad) begin
			report      <= REPORT_BAD;
			channel     <= '0;
			value       <= '0;
			failsafe    <= failsafe_q;
			lost        <= (elapsed_q > {1'b0, timeout_q}) || failsafe_q;
			error_count <= bad_inc;
			last        <= 1'b1;
		end else if (cmd.emit_analog || cmd.emit_digital) begin
			report      <= REPORT_CHANNEL;
			channel     <= ch_q;
			if (cmd.emit_analog) begin
				value <= acc_q[CHAN_BITS-1:0];
			end else begin
				value <= dig_bit ? dig_high_q : dig_low_q;
			end
			failsafe    <= failsafe_q;
			lost        <= (elapsed_q > {1'b0, timeout_q}) || failsafe_q;
			error_count <= bad_q;
			last        <= cmd.emit_digital && (ch_q == DIG1_CH);
		end
	end

	// Checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q |-> (pos_q < FRAME_LEN))
		else $error("capture position past frame end");

	a_fetch_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> ((rd_q >= FIRST_DATA_POS) && (rd_q <= LAST_DATA_POS)))
		else $error("unpacker read outside channel bytes");

	a_emit_bits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_analog |-> (nbits_q >= NBITS_BITS'(CHAN_BITS)))
		else $error("channel emitted with too few bits");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digital |-> ((nbits_q == '0) && (rd_q == FLAGS_POS)))
		else $error("channel bits left over at digital channels");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !load)
		else $error("output register loaded while held");

endmodule

// ===== src/sbus_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// SBUS frame receiver top level: controller and datapath joined by command/status structs.
// Depends on sbfr_pkg, sbfr_ctrl and sbfr_datapath.
//
// Each input transaction carries a received serial byte or a one millisecond tick.
// A byte that does not complete a frame gives no result; a tick or a bad frame
// gives one result. A good frame completes with 18 channel results (16 analog
// channels, then two digital ones, the last flagged): the stored bytes are unpacked
// one at a time through the frame store's single registered read port, and input
// is held off from the closing byte until the last result has been given.
// A new input is taken only while the output register is empty or being emptied.
// The store needs no clearing after reset. Configuration writes take effect at once.
module sbus_frame_receiver_unit
	import sbfr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                report,
	output logic [4:0]                channel,
	output logic [10:0]               value,
	output logic                      failsafe,
	output logic                      lost,
	output logic [15:0]               error_count,
	output logic                      last
);

	sbfr_cmd_t    cmd;
	sbfr_status_t status;

	sbfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sbfr_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.report      (report),
		.channel     (channel),
		.value       (value),
		.failsafe    (failsafe),
		.lost        (lost),
		.error_count (error_count),
		.last        (last)
	);

endmodule
